// ----- sv/opt_pkg.sv -----
// Shared types, codes and constants for the ordered peer table.
package opt_pkg;

    localparam int MAX_PEERS_DEF = 16;
    localparam int ADDR_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int MTYPE_W       = 8;
    localparam int OUT_TDATA_W   = 48;
    localparam int Q_DEPTH       = 2;

    localparam logic [MTYPE_W-1:0] MSG_TYPE_LIST = 8'd2;

    // result kinds
    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_HEADER = 2'd1;
    localparam logic [1:0] RK_ENTRY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONN      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_CONN  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_REPLY,
        S_HDR,
        S_ENT
    } t_state;

endpackage

// ----- sv/opt_ram.sv -----
// Generic simple dual-port RAM with registered read.
module opt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/opt_front.sv -----
// Front end: accepts input transfers, decodes the operation and queues commands.
module opt_front
    import opt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [ADDR_W-1:0] i_s_axis_tdata,
    input  logic [KIND_W-1:0] i_s_axis_tuser,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);
    t_cmd       r_q [Q_DEPTH];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_fill, n_fill;
    logic       push;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.addr = i_s_axis_tdata;
        case (i_s_axis_tuser)
            OP_ADD:    cmd_in.op = OP_ADD;
            OP_REMOVE: cmd_in.op = OP_REMOVE;
            OP_QUERY:  cmd_in.op = OP_QUERY;
            default:   cmd_in.op = OP_DUMP;
        endcase
    end

    assign o_s_axis_tready = (r_fill != 2'(Q_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_fill != 2'd0);
    assign o_cmd           = r_q[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = i_cmd_pop ? ~r_rptr : r_rptr;
        n_fill = r_fill + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
        if (push) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

// ----- sv/opt_back.sv -----
// Back end: sequencer that runs each command against the table and drives results.
module opt_back
    import opt_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);
    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W = $clog2(MAX_PEERS + 1);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_cidx, n_cidx;
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic              r_dv, n_dv;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [1:0]             r_out_kind;
    logic                   r_out_last;

    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [ADDR_W-1:0] wr_data, rd_data;

    logic                emit;
    logic [1:0]          e_kind;
    logic [STATUS_W-1:0] e_status;
    logic [MTYPE_W-1:0]  e_mtype;
    logic [ADDR_W-1:0]   e_word;
    logic                e_last;

    logic             out_free;
    logic             full;
    logic [CNT_W-1:0] last_idx;
    logic             match;
    logic             scan_end;
    logic             shift_done;
    logic             ent_last;

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign full       = (r_count == CNT_W'(MAX_PEERS));
    assign last_idx   = r_count - 1'b1;
    assign match      = r_dv && (rd_data == r_addr);
    assign scan_end   = r_dv && (CNT_W'(r_cidx) == last_idx);
    assign shift_done = r_dv ? ((CNT_W'(r_widx) + 1'b1) == last_idx)
                             : (CNT_W'(r_widx) == last_idx);
    assign ent_last   = (CNT_W'(r_cidx) == last_idx);

    opt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_PEERS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_ADD:    n_state = S_REPLY;
                        OP_DUMP:   n_state = S_HDR;
                        default:   n_state = (r_count == '0) ? S_REPLY : S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_op == OP_REMOVE) ? S_SHIFT : S_REPLY;
                end else if (scan_end) begin
                    n_state = S_REPLY;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_HDR: begin
                if (out_free) begin
                    n_state = (r_count == '0) ? S_IDLE : S_ENT;
                end
            end
            S_ENT: begin
                if (out_free && ent_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op     = r_op;
        n_addr   = r_addr;
        n_count  = r_count;
        n_cidx   = r_cidx;
        n_widx   = r_widx;
        n_dv     = r_dv;
        n_status = r_status;
        o_cmd_pop = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_widx;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = '0;
        emit     = 1'b0;
        e_kind   = RK_STATUS;
        e_status = ST_NONE;
        e_mtype  = '0;
        e_word   = '0;
        e_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_addr    = i_cmd.addr;
                    n_dv      = 1'b0;
                    n_cidx    = '0;
                    case (i_cmd.op)
                        OP_ADD: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = r_count[IDX_W-1:0];
                                wr_data  = i_cmd.addr;
                                n_count  = r_count + 1'b1;
                                n_status = ST_ADDED;
                            end
                        end
                        OP_REMOVE: n_status = ST_NOT_FOUND;
                        OP_QUERY:  n_status = ST_NOT_CONN;
                        default:   n_status = ST_NONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    if (r_op == OP_REMOVE) begin
                        n_widx = r_cidx;
                        n_dv   = 1'b0;
                    end else begin
                        n_status = ST_CONN;
                    end
                end else if (!scan_end) begin
                    // read one ahead of the compare
                    rd_en   = 1'b1;
                    rd_addr = r_dv ? IDX_W'(r_cidx + 1'b1) : '0;
                    n_cidx  = rd_addr;
                    n_dv    = 1'b1;
                end
            end
            S_SHIFT: begin
                // entry widx takes the one above it; read runs one ahead
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_widx;
                    wr_data = rd_data;
                end
                if (shift_done) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_REMOVED;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_dv ? IDX_W'(r_widx + 2'd2) : IDX_W'(r_widx + 1'b1);
                    n_widx  = r_dv ? IDX_W'(r_widx + 1'b1) : r_widx;
                    n_dv    = 1'b1;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = r_status;
                end
            end
            S_HDR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = RK_HEADER;
                    e_mtype = MSG_TYPE_LIST;
                    e_word  = ADDR_W'(r_count);
                    e_last  = (r_count == '0);
                    if (r_count != '0) begin
                        rd_en  = 1'b1;
                        rd_addr = '0;
                        n_cidx = '0;
                    end
                end
            end
            S_ENT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = RK_ENTRY;
                    e_word = rd_data;
                    e_last = ent_last;
                    if (!ent_last) begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(r_cidx + 1'b1);
                        n_cidx  = rd_addr;
                    end
                end
            end
            default: ;
        endcase
    end

    assign n_out_valid = emit ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_cidx   <= n_cidx;
        r_widx   <= n_widx;
        r_status <= n_status;
        if (emit) begin
            r_out_data <= OUT_TDATA_W'({e_word, e_mtype, e_status});
            r_out_kind <= e_kind;
            r_out_last <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- sv/ordered_peer_table.sv -----
// Ordered peer table: add, remove with compaction, query and dump of 32-bit addresses.
//
// Holds up to MAX_PEERS addresses in insertion order in a single simple dual-port
// RAM. Commands are taken into a two-entry queue, so up to two items are accepted
// while the sequencer is busy. An add writes at the tail without a scan; a query
// or remove on a non-empty table scans the held entries in order until it finds the
// address or passes the last one, and a remove that hits then shifts the tail down.
// A dump emits a header and then one result per cycle while the output is not
// stalled. Scans, shifts and dumps use the one RAM read port, one entry per cycle;
// replies and dump results also wait on output backpressure. No clearing pass is
// needed after reset.
module ordered_peer_table
    import opt_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [ADDR_W-1:0]      i_s_axis_tdata,  // [31:0] peer_address
    input  logic [KIND_W-1:0]      i_s_axis_tuser,  // [1:0] kind
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [2:0] status, [10:3] message_type, [42:11] word, [47:43] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]             o_m_axis_tuser,  // [1:0] result_kind
    output logic                   o_m_axis_tlast   // last
);
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    opt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    opt_back #(
        .MAX_PEERS (MAX_PEERS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- sv/opt_checker.sv -----
// Port-level assertions for the ordered peer table, bound to the top level.
module opt_checker
    import opt_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input logic [1:0]             i_m_axis_tuser,
    input logic                   i_m_axis_tlast
);
    logic [STATUS_W-1:0] status;
    logic [MTYPE_W-1:0]  mtype;
    logic [ADDR_W-1:0]   word;

    assign status = i_m_axis_tdata[2:0];
    assign mtype  = i_m_axis_tdata[10:3];
    assign word   = i_m_axis_tdata[42:11];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser)
            && $stable(i_m_axis_tlast))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("output valid right after reset");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == RK_STATUS |-> i_m_axis_tlast && word == '0)
        else $error("status reply without last or with nonzero word");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == RK_HEADER |->
            mtype == MSG_TYPE_LIST && status == ST_NONE
            && word <= ADDR_W'(MAX_PEERS) && (i_m_axis_tlast == (word == '0)))
        else $error("malformed dump header");

    a_entry_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tready && !i_m_axis_tlast |=>
            !i_m_axis_tvalid || i_m_axis_tuser == RK_ENTRY)
        else $error("non-entry result inside a dump");

endmodule

bind ordered_peer_table opt_checker #(
    .MAX_PEERS (MAX_PEERS)
) u_opt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
